// ===== rtl/core/dpta_pkg.sv =====
// ----------------------------------------------------------------------------
// dpta_pkg
// Shared types, codes and constants of the device presence table.
// ----------------------------------------------------------------------------
package dpta_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Event codes carried on the result word
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_ONLINE     = 4'd1;
    localparam logic [3:0] EV_MODIFIED   = 4'd2;
    localparam logic [3:0] EV_OFFLINE    = 4'd3;
    localparam logic [3:0] EV_OWN        = 4'd4;
    localparam logic [3:0] EV_SHORT      = 4'd5;
    localparam logic [3:0] EV_BAD_HEADER = 4'd6;
    localparam logic [3:0] EV_WRONG_TYPE = 4'd7;
    localparam logic [3:0] EV_TABLE_FULL = 4'd8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPIRY        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOVERY_TYPE = 2'd3;
    localparam int CFG_DATA_W = 32;

    // Register values after reset
    localparam logic [31:0] RST_OWN_ADDRESS    = 32'd0;
    localparam logic [31:0] RST_EXPIRY         = 32'd1000;
    localparam logic [15:0] RST_MIN_LENGTH     = 16'd16;
    localparam logic [7:0]  RST_DISCOVERY_TYPE = 8'd1;

    // Stream widths
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 104;

    typedef struct packed {
        logic [31:0] own_address;
        logic [31:0] expiry_interval;
        logic [15:0] min_packet_length;
        logic [7:0]  discovery_type_code;
    } cfg_t;

    typedef struct packed {
        logic        operation;
        logic [31:0] source_address;
        logic [15:0] packet_length;
        logic        header_valid;
        logic [7:0]  message_type;
        logic [63:0] name_id;
        logic [7:0]  category;
        logic [31:0] now_ticks;
    } item_t;

    // One table row as held in the entry memory
    typedef struct packed {
        logic [31:0] last_seen;
        logic [7:0]  category;
        logic [63:0] name;
        logic [31:0] address;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [3:0]  event_res;
        logic [31:0] device_address;
        logic [63:0] device_name_id;
        logic [7:0]  device_category;
        logic        last;
    } result_t;

endpackage

// ===== rtl/core/dpta_ram.sv =====
// ----------------------------------------------------------------------------
// dpta_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module dpta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/dpta_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpta_ctrl
// Sequencer of the presence table: packet checks, slot-by-slot lookup and
// sweep over the entry memory, valid bits and the result register.
// ----------------------------------------------------------------------------
module dpta_ctrl import dpta_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  item_t               in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output result_t             out_res,
    output logic                ram_we,
    output logic [IDX_W-1:0]    ram_waddr,
    output entry_t              ram_wdata,
    output logic                ram_re,
    output logic [IDX_W-1:0]    ram_raddr,
    input  entry_t              ram_rdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHECK  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;
    localparam logic [2:0] ST_SWEEP  = 3'd5;

    logic [2:0]             state_reg, state_next;
    item_t                  item_reg, item_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   issue_reg, issue_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic                   mod_reg, mod_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_slot_reg, free_slot_next;
    logic                   pend_vld_reg, pend_vld_next;
    result_t                pend_reg, pend_next;
    logic                   out_vld_reg, out_vld_next;
    result_t                out_reg, out_next;

    logic                   push;
    result_t                push_res;
    logic                   push_ok;
    logic                   advance;
    logic                   slot_valid;
    logic                   hit;
    logic                   stale;
    logic [31:0]            age;
    result_t                stale_res;

    // Compare stage looks at the row read when the slot walk last advanced
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign hit   = cmp_vld_reg && slot_valid
                   && (ram_rdata.address == item_reg.source_address);
    assign age   = item_reg.now_ticks - ram_rdata.last_seen;
    assign stale = cmp_vld_reg && slot_valid && (age >= cfg.expiry_interval);
    assign push_ok = !out_vld_reg || out_ready;

    always_comb
    begin
        stale_res.event_res       = EV_OFFLINE;
        stale_res.device_address  = ram_rdata.address;
        stale_res.device_name_id  = ram_rdata.name;
        stale_res.device_category = ram_rdata.category;
        stale_res.last            = 1'b0;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        valid_next      = valid_reg;
        mod_next        = mod_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        pend_vld_next   = pend_vld_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_res        = '0;
        advance         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = cmp_idx_reg;
        ram_wdata.last_seen = item_reg.now_ticks;
        ram_wdata.category  = item_reg.category;
        ram_wdata.name      = item_reg.name_id;
        ram_wdata.address   = item_reg.source_address;
        in_ready        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next       = in_item;
                    free_found_next = 1'b0;
                    pend_vld_next   = 1'b0;
                    state_next      = in_item.operation ? ST_SWEEP : ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                // Reject checks in fixed priority order
                push_res.device_address = item_reg.source_address;
                push_res.last           = 1'b1;
                if (item_reg.source_address == cfg.own_address)
                begin
                    push_res.event_res = EV_OWN;
                end
                else if (item_reg.packet_length < cfg.min_packet_length)
                begin
                    push_res.event_res = EV_SHORT;
                end
                else if (!item_reg.header_valid)
                begin
                    push_res.event_res = EV_BAD_HEADER;
                end
                else if (item_reg.message_type != cfg.discovery_type_code)
                begin
                    push_res.event_res = EV_WRONG_TYPE;
                end
                else
                begin
                    push_res.event_res = EV_NONE;
                end

                if (push_res.event_res == EV_NONE)
                begin
                    state_next = ST_SCAN;
                end
                else if (push_ok)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    // Hold the matching slot in the compare stage
                    mod_next   = (ram_rdata.name != item_reg.name_id)
                                 || (ram_rdata.category != item_reg.category);
                    state_next = ST_UPDATE;
                end
                else
                begin
                    advance = 1'b1;
                    if (cmp_vld_reg && !slot_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cmp_idx_reg;
                    end
                    if (!issue_reg && !cmp_vld_reg)
                    begin
                        state_next = ST_INSERT;
                    end
                end
            end

            ST_UPDATE:
            begin
                push_res.event_res       = mod_reg ? EV_MODIFIED : EV_NONE;
                push_res.device_address  = item_reg.source_address;
                push_res.device_name_id  = item_reg.name_id;
                push_res.device_category = item_reg.category;
                push_res.last            = 1'b1;
                if (push_ok)
                begin
                    ram_we     = 1'b1;
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_INSERT:
            begin
                push_res.event_res       = free_found_reg ? EV_ONLINE : EV_TABLE_FULL;
                push_res.device_address  = item_reg.source_address;
                push_res.device_name_id  = item_reg.name_id;
                push_res.device_category = item_reg.category;
                push_res.last            = 1'b1;
                ram_waddr                = free_slot_reg;
                if (push_ok)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                    if (free_found_reg)
                    begin
                        ram_we                    = 1'b1;
                        valid_next[free_slot_reg] = 1'b1;
                    end
                end
            end

            ST_SWEEP:
            begin
                if (stale)
                begin
                    // Keep one removed row pending until the next is known
                    if (!pend_vld_reg)
                    begin
                        pend_next               = stale_res;
                        pend_vld_next           = 1'b1;
                        valid_next[cmp_idx_reg] = 1'b0;
                        advance                 = 1'b1;
                    end
                    else if (push_ok)
                    begin
                        push                    = 1'b1;
                        push_res                = pend_reg;
                        pend_next               = stale_res;
                        valid_next[cmp_idx_reg] = 1'b0;
                        advance                 = 1'b1;
                    end
                end
                else if (!issue_reg && !cmp_vld_reg)
                begin
                    if (!pend_vld_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (push_ok)
                    begin
                        push          = 1'b1;
                        push_res      = pend_reg;
                        push_res.last = 1'b1;
                        pend_vld_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot walk: issue stage reads, compare stage checks the registered row
    always_comb
    begin
        idx_next     = idx_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        if (state_reg == ST_IDLE)
        begin
            idx_next     = '0;
            issue_next   = 1'b1;
            cmp_vld_next = 1'b0;
        end
        else if (advance)
        begin
            cmp_vld_next = issue_reg;
            cmp_idx_next = idx_reg;
            if (issue_reg)
            begin
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    assign ram_re    = advance && issue_reg;
    assign ram_raddr = idx_reg;

    // Result register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (push)
        begin
            out_vld_next = 1'b1;
            out_next     = push_res;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            issue_reg      <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            issue_reg      <= issue_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        mod_reg       <= mod_next;
        free_slot_reg <= free_slot_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

endmodule

// ===== rtl/core/device_presence_table_aging.sv =====
// Sequence: a rejected packet's result is registered from the check state; a lookup walks
// the table at one slot per cycle, over at most TABLE_DEPTH slots.
// A sweep ends once the last slot is compared and its final result is sent; output stalls hold it.
// Throughput: one item at a time, the next accepted once the final result is registered.
// Reset: configuration to defaults, all valid bits cleared at once, table empty.
// ----------------------------------------------------------------------------
// device_presence_table_aging
// Neighbor table with aging: discovery packet checks, lookup and insert, and
// sweep of stale entries over a memory-held table.
// ----------------------------------------------------------------------------
module device_presence_table_aging import dpta_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // source_address[31:0], packet_length[47:32], header_valid[48],
    // message_type[56:49], name_id[120:57], category[128:121],
    // now_ticks[160:129], zero fill[167:161]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                  s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // device_address[31:0], device_name_id[95:32], device_category[103:96]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // event_res[3:0]
    output logic [3:0]            m_tuser,
    output logic                  m_tlast
);

    cfg_t    cfg_reg, cfg_next;
    item_t   in_item;
    result_t out_res;
    logic    ram_we;
    logic    ram_re;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t  ram_wdata;
    entry_t  ram_rdata;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_OWN_ADDRESS:    cfg_next.own_address         = cfg_wdata;
                REG_EXPIRY:         cfg_next.expiry_interval     = cfg_wdata;
                REG_MIN_LENGTH:     cfg_next.min_packet_length   = cfg_wdata[15:0];
                REG_DISCOVERY_TYPE: cfg_next.discovery_type_code = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address         <= RST_OWN_ADDRESS;
            cfg_reg.expiry_interval     <= RST_EXPIRY;
            cfg_reg.min_packet_length   <= RST_MIN_LENGTH;
            cfg_reg.discovery_type_code <= RST_DISCOVERY_TYPE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Unpack the input word
    always_comb
    begin
        in_item.operation      = s_tuser;
        in_item.source_address = s_tdata[31:0];
        in_item.packet_length  = s_tdata[47:32];
        in_item.header_valid   = s_tdata[48];
        in_item.message_type   = s_tdata[56:49];
        in_item.name_id        = s_tdata[120:57];
        in_item.category       = s_tdata[128:121];
        in_item.now_ticks      = s_tdata[160:129];
    end

    dpta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dpta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Pack the result word
    assign m_tdata = {out_res.device_category, out_res.device_name_id,
                      out_res.device_address};
    assign m_tuser = out_res.event_res;
    assign m_tlast = out_res.last;

endmodule

// ===== rtl/core/dpta_checker.sv =====
// ----------------------------------------------------------------------------
// dpta_checker
// Port-level checks on the presence table, bound to the top level.
// ----------------------------------------------------------------------------
module dpta_checker import dpta_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [3:0]           m_tuser,
    input  logic                 m_tlast
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed while stalled");

    // One item at a time: no second word right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Event codes stay in range
    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= EV_TABLE_FULL)
        else $error("event code out of range");

    // Discovery results are single and therefore last
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_OFFLINE |-> m_tlast)
        else $error("discovery result without last");

    // Rejects carry no name or category
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == EV_OWN || m_tuser == EV_SHORT
                     || m_tuser == EV_BAD_HEADER || m_tuser == EV_WRONG_TYPE)
        |-> m_tdata[103:32] == '0)
        else $error("reject result carries entry data");

endmodule

bind device_presence_table_aging dpta_checker u_dpta_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
